FILE: rtl/paft_pkg.sv
// Package for the PWM audio FIFO timer: operation codes, register indexes,
// FIFO sizing, routing decode and latch scaling. No dependencies.
package paft_pkg;

  localparam int FifoDepth = 4;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int SmpW      = 12;
  localparam int TimeW     = 32;
  localparam int AddrW     = 5;

  typedef enum logic [1:0] {
    FuncTick  = 2'd0,
    FuncPushL = 2'd1,
    FuncPushR = 2'd2,
    FuncLoad  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    RegPeriod   = 3'd0,
    RegIrqIntvl = 3'd1,
    RegMode     = 3'd2,
    RegAudioEn  = 3'd3,
    RegMIrqEn   = 3'd4,
    RegSIrqEn   = 3'd5
  } reg_e;

  localparam logic [4:0] IrqIntvlMax = 5'd16;

  typedef struct packed {
    logic l_en;
    logic l_to_right;
    logic r_en;
    logic r_to_left;
  } route_t;

  typedef struct packed {
    logic l_pop;
    logic l_to_right;
    logic r_pop;
    logic r_to_left;
    logic irq_m;
    logic irq_s;
    logic dma;
    logic l_full;
    logic l_empty;
    logic r_full;
    logic r_empty;
  } s1_t;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(FifoDepth - 1)) r = '0;
    else r = p + PtrW'(1);
    return r;
  endfunction

  function automatic route_t route_decode(input logic [3:0] m);
    route_t r;
    r = '0;
    unique case (m)
      4'h1, 4'hD: r.l_en = 1'b1;
      4'h2, 4'hE: begin
        r.l_en       = 1'b1;
        r.l_to_right = 1'b1;
      end
      4'h4, 4'h7: begin
        r.r_en      = 1'b1;
        r.r_to_left = 1'b1;
      end
      4'h5, 4'h9: begin
        r.l_en = 1'b1;
        r.r_en = 1'b1;
      end
      4'h6, 4'hA: begin
        r.l_en       = 1'b1;
        r.l_to_right = 1'b1;
        r.r_en       = 1'b1;
        r.r_to_left  = 1'b1;
      end
      4'h8, 4'hB: r.r_en = 1'b1;
      default: r = '0;
    endcase
    return r;
  endfunction

  // (latch - (period/2 + 1)) * 128, saturated to 16 bits signed; 0 if disabled or latch is 0
  function automatic logic [15:0] scale(input logic [SmpW-1:0] lat,
                                        input logic [11:0] period,
                                        input logic en);
    logic [12:0] diff;
    logic [15:0] r;
    diff = {1'b0, lat} - ({2'b00, period[11:1]} + 13'd1);
    if (!en || lat == '0) r = 16'h0000;
    else if (!diff[12] && diff[11:8] != 4'h0) r = 16'h7FFF;
    else if (diff[12] && diff[11:8] != 4'hF) r = 16'h8000;
    else r = {diff[8:0], 7'b0};
    return r;
  endfunction

endpackage

FILE: rtl/pwm_audio_fifo_timer.sv
// PWM audio FIFO timer top level: sample FIFO memories, expiry timer,
// routing into output latches and interrupt/DMA flags. Uses paft_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per
//   transfer: tick with current time, push left, push right, load timer
//   base. Output channel (out_valid_o / out_stall_i) returns exactly one
//   result per input transfer, in order.
//   A result passes through the memory read stage and then the output
//   register, and can transfer out once it is in the output register.
//   Throughput: one transfer per cycle while the output is not stalled;
//   the FIFO memories are read in the stage ahead of the latch update,
//   and their registered read sets the two-stage pipeline.
//   Stall: while out_stall_i holds a result, one more item can be taken
//   into the memory read stage; after that in_stall_o rises until the
//   output drains.
//   Reset: registers take their defaults, FIFOs empty, latches zero; no
//   clearing pass, items are taken as soon as reset is released.
//   The user must write registers through the APB port only while idle; the block does not enforce it.
module pwm_audio_fifo_timer
  import paft_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AddrW-1:0]        paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic [TimeW-1:0]        time_req_i,
  input  logic [SmpW-1:0]         sample_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SmpW-1:0]         left_raw_o,
  output logic [SmpW-1:0]         right_raw_o,
  output logic signed [15:0]      left_scaled_o,
  output logic signed [15:0]      right_scaled_o,
  output logic                    irq_master_o,
  output logic                    irq_slave_o,
  output logic                    dma_request_o,
  output logic                    left_full_o,
  output logic                    left_empty_o,
  output logic                    right_full_o,
  output logic                    right_empty_o
);

  logic [11:0] period_q;
  logic [4:0]  irq_intvl_q;
  logic [7:0]  mode_q;
  logic        audio_en_q, mirq_en_q, sirq_en_q;
  logic        cfg_wr;
  logic [3:0]  intvl_wr;

  logic [SmpW-1:0] l_mem [FifoDepth];
  logic [SmpW-1:0] r_mem [FifoDepth];
  logic [SmpW-1:0] l_rdata_q, r_rdata_q;

  logic [PtrW-1:0] l_rp_q, l_wp_q, r_rp_q, r_wp_q;
  logic [PtrW-1:0] l_rp_d, l_wp_d, r_rp_d, r_wp_d;
  logic [TimeW-1:0] expiry_q, expiry_d;
  logic [4:0]  cd_q, cd_d, cd_dec;

  logic        accept, s2_move, s1_valid_q, out_valid_q;
  s1_t         s1_d, s1_q;
  route_t      rt;
  func_e       func;
  logic        expire, l_wr, r_wr;

  logic [SmpW-1:0] l_lat_q, l_lat_d, r_lat_q, r_lat_d;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign intvl_wr = pwdata[3:0];

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      RegPeriod:   prdata = {20'b0, period_q};
      RegIrqIntvl: prdata = {27'b0, irq_intvl_q};
      RegMode:     prdata = {24'b0, mode_q};
      RegAudioEn:  prdata = {31'b0, audio_en_q};
      RegMIrqEn:   prdata = {31'b0, mirq_en_q};
      RegSIrqEn:   prdata = {31'b0, sirq_en_q};
      default:     prdata = '0;
    endcase
  end

  // pipeline control
  assign s2_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s2_move;
  assign accept     = in_valid_i && !in_stall_o;
  assign func       = func_e'(func_i);

  always_comb begin
    rt       = route_decode(mode_q[3:0]);
    l_rp_d   = l_rp_q;
    l_wp_d   = l_wp_q;
    r_rp_d   = r_rp_q;
    r_wp_d   = r_wp_q;
    expiry_d = expiry_q;
    cd_dec   = cd_q - {4'b0, (cd_q != 5'd0)};
    cd_d     = cd_q;
    l_wr     = 1'b0;
    r_wr     = 1'b0;
    expire   = 1'b0;
    s1_d     = '0;
    unique case (func)
      FuncPushL: begin
        if (ptr_next(l_wp_q) != l_rp_q) begin
          l_wr   = 1'b1;
          l_wp_d = ptr_next(l_wp_q);
        end
      end
      FuncPushR: begin
        if (ptr_next(r_wp_q) != r_rp_q) begin
          r_wr   = 1'b1;
          r_wp_d = ptr_next(r_wp_q);
        end
      end
      FuncLoad: expiry_d = time_req_i;
      FuncTick: begin
        expire = (mode_q[3:0] != 4'h0) && (period_q != 12'h000) &&
                 (expiry_q <= time_req_i);
      end
      default: expire = 1'b0;
    endcase
    if (expire) begin
      s1_d.l_pop      = rt.l_en && (l_rp_q != l_wp_q);
      s1_d.l_to_right = rt.l_to_right;
      s1_d.r_pop      = rt.r_en && (r_rp_q != r_wp_q);
      s1_d.r_to_left  = rt.r_to_left;
      if (s1_d.l_pop) l_rp_d = ptr_next(l_rp_q);
      if (s1_d.r_pop) r_rp_d = ptr_next(r_rp_q);
      expiry_d = expiry_q + {20'b0, period_q};
      cd_d     = cd_dec;
      if (cd_dec == 5'd0) begin
        cd_d       = irq_intvl_q;
        s1_d.dma   = mode_q[7];
        s1_d.irq_m = mirq_en_q;
        s1_d.irq_s = sirq_en_q;
      end
    end
    s1_d.l_full  = ptr_next(l_wp_d) == l_rp_d;
    s1_d.l_empty = l_rp_d == l_wp_d;
    s1_d.r_full  = ptr_next(r_wp_d) == r_rp_d;
    s1_d.r_empty = r_rp_d == r_wp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= 12'hFFF;
      irq_intvl_q <= IrqIntvlMax;
      mode_q      <= '0;
      audio_en_q  <= 1'b1;
      mirq_en_q   <= 1'b0;
      sirq_en_q   <= 1'b0;
      cd_q        <= IrqIntvlMax;
      l_rp_q      <= '0;
      l_wp_q      <= '0;
      r_rp_q      <= '0;
      r_wp_q      <= '0;
      expiry_q    <= '0;
      s1_valid_q  <= 1'b0;
      s1_q        <= '0;
      out_valid_q <= 1'b0;
      l_lat_q     <= '0;
      r_lat_q     <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[4:2])
          RegPeriod: period_q <= pwdata[11:0];
          RegIrqIntvl: begin
            irq_intvl_q <= (intvl_wr == 4'h0) ? IrqIntvlMax : {1'b0, intvl_wr};
            cd_q        <= (intvl_wr == 4'h0) ? IrqIntvlMax : {1'b0, intvl_wr};
          end
          RegMode:    mode_q     <= pwdata[7:0];
          RegAudioEn: audio_en_q <= pwdata[0];
          RegMIrqEn:  mirq_en_q  <= pwdata[0];
          RegSIrqEn:  sirq_en_q  <= pwdata[0];
          default: ;
        endcase
      end
      if (accept) begin
        l_rp_q   <= l_rp_d;
        l_wp_q   <= l_wp_d;
        r_rp_q   <= r_rp_d;
        r_wp_q   <= r_wp_d;
        expiry_q <= expiry_d;
        cd_q     <= cd_d;
        s1_q     <= s1_d;
      end
      if (accept) s1_valid_q <= 1'b1;
      else if (s2_move) s1_valid_q <= 1'b0;
      if (s2_move) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          l_lat_q <= l_lat_d;
          r_lat_q <= r_lat_d;
        end
      end
    end
  end

  // FIFO memories: one write port, registered read at the read pointer
  always_ff @(posedge clk_i) begin
    if (accept && l_wr) l_mem[l_wp_q] <= sample_i;
    if (accept && r_wr) r_mem[r_wp_q] <= sample_i;
    if (accept) begin
      l_rdata_q <= l_mem[l_rp_q];
      r_rdata_q <= r_mem[r_rp_q];
    end
  end

  always_comb begin
    l_lat_d = l_lat_q;
    r_lat_d = r_lat_q;
    if (s1_q.l_pop) begin
      if (s1_q.l_to_right) r_lat_d = l_rdata_q;
      else l_lat_d = l_rdata_q;
    end
    if (s1_q.r_pop) begin
      if (s1_q.r_to_left) l_lat_d = r_rdata_q;
      else r_lat_d = r_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_move && s1_valid_q) begin
      left_raw_o     <= l_lat_d;
      right_raw_o    <= r_lat_d;
      left_scaled_o  <= $signed(scale(l_lat_d, period_q, audio_en_q));
      right_scaled_o <= $signed(scale(r_lat_d, period_q, audio_en_q));
      irq_master_o   <= s1_q.irq_m;
      irq_slave_o    <= s1_q.irq_s;
      dma_request_o  <= s1_q.dma;
      left_full_o    <= s1_q.l_full;
      left_empty_o   <= s1_q.l_empty;
      right_full_o   <= s1_q.r_full;
      right_empty_o  <= s1_q.r_empty;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: tb/pwm_audio_fifo_timer_checker.sv
`timescale 1ns / 100ps
// Checker for pwm_audio_fifo_timer: tracks APB writes and input transfers,
// predicts each output transfer and compares it field by field. Uses paft_pkg.
module pwm_audio_fifo_timer_checker
  import paft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         func_i,
  input  logic [TimeW-1:0]   time_req_i,
  input  logic [SmpW-1:0]    sample_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [SmpW-1:0]    left_raw_i,
  input  logic [SmpW-1:0]    right_raw_i,
  input  logic signed [15:0] left_scaled_i,
  input  logic signed [15:0] right_scaled_i,
  input  logic               irq_master_i,
  input  logic               irq_slave_i,
  input  logic               dma_request_i,
  input  logic               left_full_i,
  input  logic               left_empty_i,
  input  logic               right_full_i,
  input  logic               right_empty_i,
  output int                 mismatches_o,
  output int                 outstanding_o
);

  typedef struct {
    logic [SmpW-1:0]    l_raw;
    logic [SmpW-1:0]    r_raw;
    logic signed [15:0] l_pcm;
    logic signed [15:0] r_pcm;
    logic               irq_m;
    logic               irq_s;
    logic               dma;
    logic               l_full;
    logic               l_empty;
    logic               r_full;
    logic               r_empty;
  } pwm_frame_t;

  logic [11:0]     period_q;
  logic [4:0]      intvl_q;
  logic [7:0]      mode_q;
  logic            aen_q;
  logic            men_q;
  logic            sen_q;
  logic [SmpW-1:0] l_mem [FifoDepth];
  logic [SmpW-1:0] r_mem [FifoDepth];
  logic [PtrW-1:0] l_rd, l_wr, r_rd, r_wr;
  logic [31:0]     expiry_q;
  logic [4:0]      countdown_q;
  logic [SmpW-1:0] l_latch, r_latch;
  pwm_frame_t      frame_q [$];
  int              results_seen;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (int'(p) == FifoDepth - 1) ? '0 : p + 1'b1;
  endfunction

  function automatic logic signed [15:0] to_pcm(input logic [SmpW-1:0] lat);
    int v;
    if (!aen_q || lat == '0) return '0;
    v = (int'(lat) - (int'(period_q >> 1) + 1)) * 128;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches_o++;
    $display("%0t: result %0d: %s", $time, results_seen, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  task automatic apply_reg(input logic [AddrW-1:0] a, input logic [31:0] d);
    case (reg_e'(a[AddrW-1:2]))
      RegPeriod:   period_q = d[11:0];
      RegIrqIntvl: begin
        intvl_q     = (d[3:0] == 4'h0) ? IrqIntvlMax : {1'b0, d[3:0]};
        countdown_q = intvl_q;
      end
      RegMode:     mode_q = d[7:0];
      RegAudioEn:  aen_q = d[0];
      RegMIrqEn:   men_q = d[0];
      RegSIrqEn:   sen_q = d[0];
      default: ;
    endcase
  endtask

  task automatic play_op(input logic [1:0] f, input logic [31:0] t,
                         input logic [SmpW-1:0] s, output pwm_frame_t fr);
    logic pop_l, pop_r, l_cross, r_cross;
    pop_l    = 1'b0;
    pop_r    = 1'b0;
    l_cross  = 1'b0;
    r_cross  = 1'b0;
    fr.irq_m = 1'b0;
    fr.irq_s = 1'b0;
    fr.dma   = 1'b0;
    case (func_e'(f))
      FuncPushL: if (bump(l_wr) != l_rd) begin
        l_mem[l_wr] = s;
        l_wr = bump(l_wr);
      end
      FuncPushR: if (bump(r_wr) != r_rd) begin
        r_mem[r_wr] = s;
        r_wr = bump(r_wr);
      end
      FuncLoad: expiry_q = t;
      FuncTick: if (mode_q[3:0] != 4'h0 && period_q != 12'h0 && expiry_q <= t) begin
        case (mode_q[3:0])
          4'h1, 4'hD: pop_l = 1'b1;
          4'h2, 4'hE: begin
            pop_l   = 1'b1;
            l_cross = 1'b1;
          end
          4'h4, 4'h7: begin
            pop_r   = 1'b1;
            r_cross = 1'b1;
          end
          4'h5, 4'h9: begin
            pop_l = 1'b1;
            pop_r = 1'b1;
          end
          4'h6, 4'hA: begin
            pop_l   = 1'b1;
            l_cross = 1'b1;
            pop_r   = 1'b1;
            r_cross = 1'b1;
          end
          4'h8, 4'hB: pop_r = 1'b1;
          default: ;
        endcase
        // an empty source leaves its target latch alone
        if (pop_l && l_rd != l_wr) begin
          if (l_cross) r_latch = l_mem[l_rd];
          else l_latch = l_mem[l_rd];
          l_rd = bump(l_rd);
        end
        if (pop_r && r_rd != r_wr) begin
          if (r_cross) l_latch = r_mem[r_rd];
          else r_latch = r_mem[r_rd];
          r_rd = bump(r_rd);
        end
        expiry_q = expiry_q + {20'h0, period_q};
        if (countdown_q != 5'd0) countdown_q = countdown_q - 5'd1;
        if (countdown_q == 5'd0) begin
          countdown_q = intvl_q;
          fr.dma      = mode_q[7];
          fr.irq_m    = men_q;
          fr.irq_s    = sen_q;
        end
      end
      default: ;
    endcase
    fr.l_raw   = l_latch;
    fr.r_raw   = r_latch;
    fr.l_pcm   = to_pcm(l_latch);
    fr.r_pcm   = to_pcm(r_latch);
    fr.l_full  = (bump(l_wr) == l_rd);
    fr.l_empty = (l_rd == l_wr);
    fr.r_full  = (bump(r_wr) == r_rd);
    fr.r_empty = (r_rd == r_wr);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pwm_frame_t want;
    if (!rst_ni) begin
      period_q    = 12'hFFF;
      intvl_q     = IrqIntvlMax;
      mode_q      = 8'h00;
      aen_q       = 1'b1;
      men_q       = 1'b0;
      sen_q       = 1'b0;
      foreach (l_mem[i]) begin
        l_mem[i] = '0;
        r_mem[i] = '0;
      end
      l_rd         = '0;
      l_wr         = '0;
      r_rd         = '0;
      r_wr         = '0;
      expiry_q     = '0;
      countdown_q  = IrqIntvlMax;
      l_latch      = '0;
      r_latch      = '0;
      results_seen = 0;
      mismatches_o = 0;
      frame_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frame_q.size() == 0) begin
          report_mismatch("output transfer with nothing pending");
        end else begin
          want = frame_q.pop_front();
          check_field("left_raw", left_raw_i, want.l_raw);
          check_field("right_raw", right_raw_i, want.r_raw);
          check_field("left_scaled", left_scaled_i, want.l_pcm);
          check_field("right_scaled", right_scaled_i, want.r_pcm);
          check_field("irq_master", irq_master_i, want.irq_m);
          check_field("irq_slave", irq_slave_i, want.irq_s);
          check_field("dma_request", dma_request_i, want.dma);
          check_field("left_full", left_full_i, want.l_full);
          check_field("left_empty", left_empty_i, want.l_empty);
          check_field("right_full", right_full_i, want.r_full);
          check_field("right_empty", right_empty_i, want.r_empty);
        end
        results_seen++;
      end
      if (psel && penable && pwrite && pready) apply_reg(paddr, pwdata);
      if (in_valid_i && !in_stall_i) begin
        play_op(func_i, time_req_i, sample_i, want);
        frame_q.push_back(want);
      end
      outstanding_o <= frame_q.size();
    end
  end

endmodule

FILE: tb/pwm_audio_fifo_timer_test.sv
`timescale 1ns / 100ps
// Testbench top for pwm_audio_fifo_timer: clock, reset, APB setup, operation
// stimulus and output stall. Needs paft_pkg, the DUT and the checker module.
module pwm_audio_fifo_timer_test;
  import paft_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  func_e              func;
  logic [TimeW-1:0]   time_req;
  logic [SmpW-1:0]    sample;
  logic               out_valid;
  logic               out_stall;
  logic [SmpW-1:0]    left_raw;
  logic [SmpW-1:0]    right_raw;
  logic signed [15:0] left_scaled;
  logic signed [15:0] right_scaled;
  logic               irq_master;
  logic               irq_slave;
  logic               dma_request;
  logic               left_full;
  logic               left_empty;
  logic               right_full;
  logic               right_empty;
  int                 mismatches;
  int                 outstanding;

  bit                 tx_calm;
  bit                 rx_calm;
  bit                 hold_off_req;
  logic [11:0]        cur_period;
  logic [31:0]        now_t;

  pwm_audio_fifo_timer u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .time_req_i     (time_req),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_raw_o     (left_raw),
    .right_raw_o    (right_raw),
    .left_scaled_o  (left_scaled),
    .right_scaled_o (right_scaled),
    .irq_master_o   (irq_master),
    .irq_slave_o    (irq_slave),
    .dma_request_o  (dma_request),
    .left_full_o    (left_full),
    .left_empty_o   (left_empty),
    .right_full_o   (right_full),
    .right_empty_o  (right_empty)
  );

  pwm_audio_fifo_timer_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .func_i         (func),
    .time_req_i     (time_req),
    .sample_i       (sample),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .left_raw_i     (left_raw),
    .right_raw_i    (right_raw),
    .left_scaled_i  (left_scaled),
    .right_scaled_i (right_scaled),
    .irq_master_i   (irq_master),
    .irq_slave_i    (irq_slave),
    .dma_request_i  (dma_request),
    .left_full_i    (left_full),
    .left_empty_i   (left_empty),
    .right_full_i   (right_full),
    .right_empty_i  (right_empty),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // output side: random stalls, calm stretches and one long hold-off on request
  initial begin : rx_side
    int n;
    out_stall <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (n = 0; n < 64; n++) @(posedge clk);
      end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
        out_stall <= 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_op(input func_e f, input logic [31:0] t, input logic [11:0] s);
    int r;
    int gap;
    gap = 0;
    if (!tx_calm) begin
      r = $urandom_range(0, 99);
      if (r >= 93) gap = $urandom_range(6, 25);
      else if (r >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    time_req <= t;
    sample   <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input reg_e r, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(int'(r) * 4);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic configure(input logic [11:0] per, input logic [4:0] intvl,
                           input logic [7:0] md, input bit aen, input bit men,
                           input bit sen);
    wait_drain();
    write_reg(RegPeriod, {20'h0, per});
    write_reg(RegIrqIntvl, {27'h0, intvl});
    write_reg(RegMode, {24'h0, md});
    write_reg(RegAudioEn, {31'h0, aen});
    write_reg(RegMIrqEn, {31'h0, men});
    write_reg(RegSIrqEn, {31'h0, sen});
    psel       <= 1'b0;
    penable    <= 1'b0;
    cur_period = per;
  endtask

  // ticks that walk time forward and pushes in about equal share, plus
  // base loads and ticks at arbitrary times
  task automatic run_random(input int n, input bit pressure);
    int          i;
    int          r;
    int          pick;
    logic [11:0] smp;
    logic [31:0] t;
    for (i = 0; i < n; i++) begin
      if (pressure && i == 10) begin
        hold_off_req = 1'b1;
        tx_calm      = 1'b1;
      end
      if (pressure && i == 40) tx_calm = 1'b0;
      pick = $urandom_range(0, 9);
      smp  = (pick == 0) ? 12'h000 : (pick == 1) ? 12'hFFF : 12'($urandom_range(0, 4095));
      r    = $urandom_range(0, 99);
      if (r < 22) begin
        send_op(FuncPushL, $urandom, smp);
      end else if (r < 44) begin
        send_op(FuncPushR, $urandom, smp);
      end else if (r < 88) begin
        now_t = now_t + $urandom_range(0, 2 * int'(cur_period) + 1);
        send_op(FuncTick, now_t, smp);
      end else if (r < 94) begin
        send_op(FuncTick, $urandom, smp);
      end else begin
        t = (r < 97) ? now_t - $urandom_range(0, 64) : $urandom;
        send_op(FuncLoad, t, smp);
        now_t = t;
      end
    end
  endtask

  initial begin : stimulus
    int k;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    func         <= FuncTick;
    time_req     <= '0;
    sample       <= '0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    hold_off_req = 1'b0;
    cur_period   = 12'hFFF;
    now_t        = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: routing off, so the tick changes nothing
    send_op(FuncTick, 32'h0, 12'h000);
    send_op(FuncPushL, 32'hFFFF_FFFF, 12'hFFF);
    send_op(FuncPushL, 32'h0, 12'h001);
    send_op(FuncPushL, 32'h0, 12'h800);
    send_op(FuncPushL, 32'h0, 12'h064);     // left full, dropped
    send_op(FuncPushR, 32'h0, 12'h000);
    send_op(FuncPushR, 32'h0, 12'hFFF);
    send_op(FuncLoad, 32'hFFFF_FFFF, 12'h000);

    configure(12'hFFF, 5'd2, 8'h85, 1'b1, 1'b1, 1'b1);
    send_op(FuncTick, 32'hFFFF_FFFE, 12'h000);  // below expiry
    send_op(FuncTick, 32'hFFFF_FFFF, 12'h000);  // expiry wraps past zero
    send_op(FuncTick, 32'h0000_0FFE, 12'h000);  // interval reached
    send_op(FuncTick, 32'h0000_1388, 12'h000);
    send_op(FuncTick, 32'hFFFF_FFFF, 12'h000);  // right source empty
    send_op(FuncPushR, 32'h0, 12'hAAA);
    send_op(FuncPushR, 32'h0, 12'h555);

    configure(12'h000, 5'd0, 8'h0A, 1'b0, 1'b0, 1'b0);
    send_op(FuncTick, 32'hFFFF_FFFF, 12'h000);  // stopped timer

    configure(12'h001, 5'd1, 8'h06, 1'b1, 1'b1, 1'b0);
    send_op(FuncPushL, 32'h0, 12'h123);
    send_op(FuncTick, 32'hFFFF_FFFF, 12'h000);
    send_op(FuncLoad, 32'h0, 12'h000);
    send_op(FuncTick, 32'h0, 12'h000);

    for (k = 0; k < 8; k++) begin
      case (k)
        0: configure(12'hFFF, 5'd16, 8'h85, 1'b1, 1'b1, 1'b1);
        1: configure(12'h000, 5'd31, 8'hFF, 1'b0, 1'b0, 1'b1);
        2: configure(12'h001, 5'd1, 8'h8A, 1'b1, 1'b1, 1'b0);
        default: configure(($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                        : 12'($urandom_range(1, 64)),
                           5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
      endcase
      tx_calm = (k == 2);
      rx_calm = (k == 2);
      run_random((k == 1) ? 60 : 215, k == 4);
      tx_calm = 1'b0;
      rx_calm = 1'b0;
    end

    wait_drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
